/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg
// types and constants shared by the huffman tree decoder modules
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int CHAR_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] CODE_LEFT  = 8'h30;
    localparam logic [CHAR_W-1:0] CODE_RIGHT = 8'h31;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } t_node;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_NEXT,
        RD_ROOT
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        t_rd_sel rd_sel;
        logic    cur_from_rd;
        logic    char_from_in;
        logic    step;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic cur_valid;
        logic leaf;
        logic out_free;
    } t_status;

endpackage

/* sv/htd_datapath.sv */
// ----------------------------------------------------------------------------
// htd_datapath
// node table, walk position, cached current node and output register
// ----------------------------------------------------------------------------
module htd_datapath #(
    parameter int NODE_COUNT = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  htd_pkg::t_cmd                    i_cmd,
    output htd_pkg::t_status                 o_status,
    input  logic                             i_s_tuser,
    input  logic [htd_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                             i_cfg_we,
    input  logic [htd_pkg::IDX_W-1:0]        i_cfg_wdata,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [htd_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int XW = htd_pkg::IDX_W + AW;

    htd_pkg::t_node r_node_mem [NODE_COUNT];
    htd_pkg::t_node r_mem_q;
    logic           r_rd_oob;

    logic [htd_pkg::IDX_W-1:0]  r_root;
    logic [htd_pkg::IDX_W-1:0]  r_pos;
    logic [htd_pkg::IDX_W-1:0]  r_next;
    logic [htd_pkg::CHAR_W-1:0] r_char;
    htd_pkg::t_node             r_cur_node;
    logic                       r_cur_valid;
    logic                       r_pf;
    logic                       r_out_valid;
    logic [htd_pkg::SYM_W-1:0]  r_out_data;

    logic [htd_pkg::IDX_W-1:0]  in_addr;
    logic [htd_pkg::CHAR_W-1:0] in_char;
    htd_pkg::t_node             wr_node;
    logic [XW-1:0]              wr_ext;
    logic                       wr_en;
    htd_pkg::t_node             rd_node;
    htd_pkg::t_node             cur_node;
    logic [htd_pkg::CHAR_W-1:0] code;
    logic [htd_pkg::IDX_W-1:0]  next_idx;
    logic [htd_pkg::IDX_W-1:0]  rd_idx;
    logic [XW-1:0]              rd_ext;
    logic                       rd_en;
    logic                       rd_ok;
    logic                       is_load;

    assign in_addr       = i_s_tdata[8:0];
    assign wr_node.left  = i_s_tdata[17:9];
    assign wr_node.right = i_s_tdata[26:18];
    assign wr_node.leaf  = i_s_tdata[27];
    assign wr_node.sym   = i_s_tdata[35:28];
    assign in_char       = i_s_tdata[43:36];

    assign is_load = i_cmd.accept && (i_s_tuser == htd_pkg::ACT_LOAD);
    assign wr_ext  = {{AW{1'b0}}, in_addr};
    assign wr_en   = is_load && (wr_ext < XW'(NODE_COUNT));

    // an index beyond the table reads as an all-zero node
    assign rd_node  = r_rd_oob ? '0 : r_mem_q;
    assign cur_node = (i_cmd.cur_from_rd || r_pf) ? rd_node : r_cur_node;
    assign code     = i_cmd.char_from_in ? in_char : r_char;

    always_comb begin
        if (code == htd_pkg::CODE_LEFT) begin
            next_idx = cur_node.left;
        end else if (code == htd_pkg::CODE_RIGHT) begin
            next_idx = cur_node.right;
        end else begin
            next_idx = r_pos;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            htd_pkg::RD_POS:  rd_idx = r_pos;
            htd_pkg::RD_NEXT: rd_idx = next_idx;
            htd_pkg::RD_ROOT: rd_idx = r_root;
            default:          rd_idx = r_pos;
        endcase
    end

    assign rd_en  = (i_cmd.rd_sel != htd_pkg::RD_NONE);
    assign rd_ext = {{AW{1'b0}}, rd_idx};
    assign rd_ok  = (rd_ext < XW'(NODE_COUNT));

    // node table, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_node_mem[wr_ext[AW-1:0]] <= wr_node;
        end
        if (rd_en) begin
            r_mem_q  <= r_node_mem[rd_ext[AW-1:0]];
            r_rd_oob <= !rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= in_char;
        end
        if (i_cmd.rd_sel == htd_pkg::RD_NEXT) begin
            r_next <= next_idx;
        end
        if (r_pf || i_cmd.step) begin
            r_cur_node <= rd_node;
        end
        if (i_cmd.emit) begin
            r_out_data <= rd_node.sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_pos       <= '0;
            r_cur_valid <= 1'b0;
            r_pf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
                r_pos  <= i_cfg_wdata;
            end else if (i_cmd.emit) begin
                r_pos <= r_root;
            end else if (i_cmd.step) begin
                r_pos <= r_next;
            end
            // a load may rewrite the cached node
            if (i_cfg_we || is_load || i_cmd.emit) begin
                r_cur_valid <= 1'b0;
            end else if (r_pf || i_cmd.step) begin
                r_cur_valid <= 1'b1;
            end
            // root node read after an emit lands in the next cycle
            r_pf <= i_cmd.emit && !is_load && !i_cfg_we;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.cur_valid = r_cur_valid || r_pf;
    assign o_status.leaf      = rd_node.leaf;
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* sv/htd_ctrl.sv */
// ----------------------------------------------------------------------------
// htd_ctrl
// sequencer for node loads and tree walk steps
// ----------------------------------------------------------------------------
module htd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tuser,
    output logic             o_s_tready,
    input  htd_pkg::t_status i_status,
    output htd_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   acc;

    assign acc = i_s_tvalid && r_ready;

    always_comb begin
        n_state            = r_state;
        o_cmd.accept       = 1'b0;
        o_cmd.rd_sel       = htd_pkg::RD_NONE;
        o_cmd.cur_from_rd  = 1'b0;
        o_cmd.char_from_in = 1'b0;
        o_cmd.step         = 1'b0;
        o_cmd.emit         = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = acc;
                if (acc && (i_s_tuser == htd_pkg::ACT_DECODE)) begin
                    if (i_status.cur_valid) begin
                        // current node on hand: go straight to the child
                        o_cmd.rd_sel       = htd_pkg::RD_NEXT;
                        o_cmd.char_from_in = 1'b1;
                        n_state            = S_CHECK;
                    end else begin
                        o_cmd.rd_sel = htd_pkg::RD_POS;
                        n_state      = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.rd_sel      = htd_pkg::RD_NEXT;
                o_cmd.cur_from_rd = 1'b1;
                n_state           = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.leaf) begin
                    if (i_status.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.rd_sel = htd_pkg::RD_ROOT;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_ready;

endmodule

/* sv/huffman_tree_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// huffman decoder walking a code tree held in an on-chip node table
// ----------------------------------------------------------------------------
// input stream: tuser selects the beat kind, 0 loads one tree node, 1 brings
// one code character. '0' steps to the left child, '1' to the right child,
// any other byte stays put. reaching a leaf sends its symbol on the output
// stream and the walk returns to the root. i_cfg_we writes the root index,
// which also restarts the walk there.
// a load beat keeps the input ready. a decode beat goes through the check
// state when the current node is already held in the datapath, and through
// fetch and then check after reset, a load or a root write; the node table
// has one registered read port and each step needs the node fetched by the
// step before. output appears in the cycle after the check that finds the
// leaf. after an emit the root node is prefetched so the next code skips fetch.
// reset clears the walk to node 0 with root 0 and empties the output
// register; the node table is not cleared and must be loaded before use.
// a stalled output register holds its symbol; loads and decodes that reach
// no leaf keep flowing, a decode that hits a leaf holds the input off until
// the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_decoder_top #(
    parameter int NODE_COUNT = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // node_address[8:0] left_child[17:9] right_child[26:18] node_is_leaf[27]
    // node_symbol[35:28] code_char[43:36], zero pad [47:44]
    input  logic [htd_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action[0]
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // symbol[7:0]
    output logic [htd_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [htd_pkg::IDX_W-1:0]     i_cfg_wdata
);

    htd_pkg::t_cmd    cmd;
    htd_pkg::t_status status;
    logic             dec_beat;
    logic             load_beat;
    logic             out_quiet;

    htd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    htd_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

    assign dec_beat  = i_s_tvalid && o_s_tready && i_s_tuser;
    assign load_beat = i_s_tvalid && o_s_tready && !i_s_tuser;
    assign out_quiet = !o_m_tvalid && o_s_tready;

    // a decode beat drops the input ready: the walker leaves idle for fetch or check
    `ASSERT_NEXT(a_decode_blocks, i_clk, i_rst_n, dec_beat, !o_s_tready, "decode beat not held")
    // a load beat completes in its own cycle
    `ASSERT_NEXT(a_load_single, i_clk, i_rst_n, load_beat, o_s_tready, "load beat stalled input")
    // a symbol only appears at the end of a walk step
    `ASSERT_NEXT(a_emit_from_walk, i_clk, i_rst_n, out_quiet, !o_m_tvalid, "symbol outside a walk")

endmodule
